>>> design/sorted_timer_event_queue_unit_macros.svh
// Assertion macros for the sorted timer event queue top level.
`ifndef SORTED_TIMER_EVENT_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define STEQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("steq assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define STEQ_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("steq assertion failed");

`endif

>>> design/steq_pkg.sv
// Types and constants of the sorted timer event queue.
package steq_pkg;

   localparam int unsigned DEADLINE_W = 32;
   localparam int unsigned HANDLE_W   = 8;
   localparam int unsigned RATE_W     = 32;
   localparam int unsigned TICKS_W    = 64;

   localparam logic [RATE_W-1:0]  TICK_RATE_RESET = 32'd19200000;
   localparam logic [TICKS_W-1:0] ARM_DISARMED    = 64'hFFFF_FFFF_FFFF_FFFF;

   // Request modes.
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_IRQ = 1'b1;

   // One queue entry as held in a cell.
   typedef struct packed {
      logic [DEADLINE_W-1:0] deadline;
      logic [HANDLE_W-1:0]   handle;
   } steq_entry_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic                  insert;
      logic                  pop;
      logic [DEADLINE_W-1:0] deadline;
      logic [HANDLE_W-1:0]   handle;
   } steq_cell_ctrl_type;

   // How the compare value of a staged result is formed.
   typedef enum logic [1:0] {
      ARM_NONE,
      ARM_DISARM,
      ARM_SCALE
   } steq_arm_type;

   typedef enum logic {
      STEQ_IDLE,
      STEQ_BUSY
   } steq_state_type;

endpackage

>>> design/steq_req_if.sv
// Request channel: one add or interrupt word.
interface steq_req_if import steq_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [DEADLINE_W-1:0] deadline;
   logic [HANDLE_W-1:0]   handle;

   modport source (output valid, output mode, output deadline, output handle, input ready);
   modport sink   (input valid, input mode, input deadline, input handle, output ready);
endinterface

>>> design/steq_rsp_if.sv
// Response channel: one result word per request.
interface steq_rsp_if import steq_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  fired;
   logic [HANDLE_W-1:0]   fired_handle;
   logic                  arm_valid;
   logic [TICKS_W-1:0]    arm_ticks;
   logic                  full_error;

   modport source (output valid, output fired, output fired_handle, output arm_valid,
                   output arm_ticks, output full_error, input ready);
   modport sink   (input valid, input fired, input fired_handle, input arm_valid,
                   input arm_ticks, input full_error, output ready);
endinterface

>>> design/steq_csr_if.sv
// Configuration write channel carrying the tick rate.
interface steq_csr_if import steq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> design/steq_cell.sv
// One cell of the sorted entry row: holds an entry and shifts with its neighbours.
module steq_cell import steq_pkg::*; (
   input  logic               clock,
   input  steq_cell_ctrl_type ctrl,
   input  logic               occupied,
   input  logic               left_gt,
   input  steq_entry_type     left_entry,
   input  steq_entry_type     right_entry,
   output steq_entry_type     entry,
   output logic               gt
);

   steq_entry_type entry_ff;
   steq_entry_type entry_in;

   // The cell is past the insertion point when its deadline is strictly later.
   assign gt    = occupied && (entry_ff.deadline > ctrl.deadline);
   assign entry = entry_ff;

   // A pop shifts towards the head; an insert shifts later entries away from it.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = right_entry;
      end else if (ctrl.insert) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || !occupied) begin
            entry_in.deadline = ctrl.deadline;
            entry_in.handle   = ctrl.handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> design/sorted_timer_event_queue_unit.sv
// Top level of the sorted timer event queue built as a row of entry cells.
//
//   channel  direction  word contents
//   req      in         mode, deadline, handle
//   rsp      out        fired, fired_handle, arm_valid, arm_ticks, full_error
//   csr      in         tick rate write data
//
// On each request the cell row is updated in the accept cycle, and the 32 by 32 bit tick
// multiplier fills the response register once that register is free or being taken.
// A new request is taken once the staged word has moved to the response register,
// so one may be accepted while an earlier response still waits.
// Reset empties the queue at once; the cells hold no reset value. csr is always ready.
`include "sorted_timer_event_queue_unit_macros.svh"

module sorted_timer_event_queue_unit import steq_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   steq_req_if.sink  req_chan,
   steq_rsp_if.source rsp_chan,
   steq_csr_if.sink  csr_chan
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   steq_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [RATE_W-1:0]     tick_rate_ff;

   // Staged word between the cell row and the multiplier.
   logic                  st_fired_ff;
   logic [HANDLE_W-1:0]   st_handle_ff;
   steq_arm_type          st_arm_ff;
   logic [DEADLINE_W-1:0] st_deadline_ff;
   logic                  st_full_ff;
   logic                  st_fired_in;
   logic [HANDLE_W-1:0]   st_handle_in;
   steq_arm_type          st_arm_in;
   logic [DEADLINE_W-1:0] st_deadline_in;
   logic                  st_full_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_fired_ff;
   logic [HANDLE_W-1:0]   rsp_handle_ff;
   logic                  rsp_arm_valid_ff;
   logic [TICKS_W-1:0]    rsp_ticks_ff;
   logic                  rsp_full_ff;
   logic [TICKS_W-1:0]    ticks_in;

   logic                  req_accept;
   logic                  stage_move;
   logic                  queue_full;
   logic                  queue_empty;
   steq_cell_ctrl_type    cell_ctrl;
   steq_entry_type        cell_entry [QUEUE_DEPTH];
   logic                  cell_gt    [QUEUE_DEPTH];

   assign req_accept  = req_chan.valid && req_chan.ready;
   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);

   // Configuration register.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
      end else if (csr_chan.valid) begin
         tick_rate_ff <= csr_chan.data;
      end
   end

   // Command for the cell row.
   always_comb begin
      cell_ctrl.insert   = req_accept && (req_chan.mode == MODE_ADD) && !queue_full;
      cell_ctrl.pop      = req_accept && (req_chan.mode == MODE_IRQ) && !queue_empty;
      cell_ctrl.deadline = req_chan.deadline;
      cell_ctrl.handle   = req_chan.handle;
   end

   // The row of cells, head at index zero.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      steq_entry_type left_entry;
      steq_entry_type right_entry;
      logic           left_gt;
      logic           occupied;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      assign occupied = (CNT_W'(i) < count_ff);

      steq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .occupied    (occupied),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .gt          (cell_gt[i])
      );
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cell_ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cell_ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result fields formed from the row before it shifts.
   always_comb begin
      st_fired_in    = 1'b0;
      st_handle_in   = '0;
      st_arm_in      = ARM_NONE;
      st_deadline_in = req_chan.deadline;
      st_full_in     = 1'b0;
      if (req_chan.mode == MODE_ADD) begin
         if (queue_full) begin
            st_full_in = 1'b1;
         end else if (queue_empty || cell_gt[0]) begin
            st_arm_in = ARM_SCALE;
         end
      end else if (queue_empty) begin
         st_arm_in = ARM_DISARM;
      end else begin
         st_fired_in  = 1'b1;
         st_handle_in = cell_entry[0].handle;
         if (count_ff == CNT_W'(1)) begin
            st_arm_in = ARM_DISARM;
         end else begin
            st_arm_in      = ARM_SCALE;
            st_deadline_in = cell_entry[1].deadline;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STEQ_IDLE: if (req_accept) state_in = STEQ_BUSY;
         STEQ_BUSY: if (stage_move) state_in = STEQ_IDLE;
         default:   state_in = STEQ_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      stage_move     = 1'b0;
      unique case (state_ff)
         STEQ_IDLE: req_chan.ready = 1'b1;
         STEQ_BUSY: stage_move = !rsp_valid_ff || rsp_chan.ready;
         default:   req_chan.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STEQ_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         st_fired_ff    <= st_fired_in;
         st_handle_ff   <= st_handle_in;
         st_arm_ff      <= st_arm_in;
         st_deadline_ff <= st_deadline_in;
         st_full_ff     <= st_full_in;
      end
   end

   // Compare value: the one multiplication, registered in the response word.
   always_comb begin
      case (st_arm_ff)
         ARM_NONE:   ticks_in = '0;
         ARM_DISARM: ticks_in = ARM_DISARMED;
         ARM_SCALE:  ticks_in = TICKS_W'(st_deadline_ff) * TICKS_W'(tick_rate_ff);
         default:    ticks_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_fired_ff     <= st_fired_ff;
         rsp_handle_ff    <= st_handle_ff;
         rsp_arm_valid_ff <= (st_arm_ff != ARM_NONE);
         rsp_ticks_ff     <= ticks_in;
         rsp_full_ff      <= st_full_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.fired        = rsp_fired_ff;
   assign rsp_chan.fired_handle = rsp_handle_ff;
   assign rsp_chan.arm_valid    = rsp_arm_valid_ff;
   assign rsp_chan.arm_ticks    = rsp_ticks_ff;
   assign rsp_chan.full_error   = rsp_full_ff;

   // The count never runs past the depth of the row.
   `STEQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   // An accepted request is staged for the multiplier in the next cycle.
   `STEQ_ASSERT_NXT(a_accept_stages, req_accept, state_ff == STEQ_BUSY)
   // Every interrupt that removes an entry re-arms the timer.
   `STEQ_ASSERT_IMP(a_fired_arms, rsp_valid_ff && rsp_fired_ff, rsp_arm_valid_ff)
   // A refused add neither fires nor re-arms.
   `STEQ_ASSERT_IMP(a_full_quiet, rsp_valid_ff && rsp_full_ff,
                    !rsp_arm_valid_ff && !rsp_fired_ff)

endmodule

>>> verif/tb_sorted_timer_event_queue_unit.sv
// Self-checking testbench for the sorted timer event queue unit.
module tb_sorted_timer_event_queue_unit;
   import steq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 250;
   localparam int SETTLE_WAIT  = 6;
   localparam int BURST_WORDS  = 60;

   // One response word as the checker sees it.
   typedef struct packed {
      logic                fired;
      logic [HANDLE_W-1:0] fired_handle;
      logic                arm_valid;
      logic [TICKS_W-1:0]  arm_ticks;
      logic                full_error;
   } timer_outcome_type;

   logic clock;
   logic reset;

   steq_req_if req_bus ();
   steq_rsp_if rsp_bus ();
   steq_csr_if csr_bus ();

   sorted_timer_event_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // Predictor state: the sorted timer list and the current tick rate.
   steq_entry_type     model_timers[$];
   logic [RATE_W-1:0]  model_tick_rate;
   timer_outcome_type  expected_outcomes[$];

   int error_count;
   int words_sent;
   int outcomes_checked;
   int fires_seen;
   int refusals_seen;
   int disarms_seen;
   int rate_writes;
   int rate_pick;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_asks;
   int cycle_count;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Timeout guard.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Scales a deadline in seconds into compare ticks at the current rate.
   function automatic logic [TICKS_W-1:0] scale_deadline(logic [DEADLINE_W-1:0] deadline);
      logic [TICKS_W-1:0] wide_deadline;
      logic [TICKS_W-1:0] wide_rate;
      wide_deadline = {32'd0, deadline};
      wide_rate     = {32'd0, model_tick_rate};
      return wide_deadline * wide_rate;
   endfunction

   // Applies one request to the predicted queue and returns the response word it causes.
   function automatic timer_outcome_type predict_timer_event(logic mode,
                                                             logic [DEADLINE_W-1:0] deadline,
                                                             logic [HANDLE_W-1:0] handle);
      timer_outcome_type outcome;
      steq_entry_type entry;
      int slot;
      outcome = '0;
      if (mode == MODE_ADD) begin
         if (model_timers.size() >= QUEUE_DEPTH) begin
            outcome.full_error = 1'b1;
         end else begin
            // Equal deadlines go behind the ones already queued.
            slot = 0;
            while (slot < model_timers.size() && model_timers[slot].deadline <= deadline)
               slot++;
            entry.deadline = deadline;
            entry.handle   = handle;
            model_timers.insert(slot, entry);
            if (slot == 0) begin
               outcome.arm_valid = 1'b1;
               outcome.arm_ticks = scale_deadline(deadline);
            end
         end
      end else begin
         outcome.arm_valid = 1'b1;
         if (model_timers.size() == 0) begin
            outcome.arm_ticks = ARM_DISARMED;
         end else begin
            outcome.fired        = 1'b1;
            outcome.fired_handle = model_timers[0].handle;
            void'(model_timers.pop_front());
            outcome.arm_ticks = (model_timers.size() == 0) ?
                                ARM_DISARMED : scale_deadline(model_timers[0].deadline);
         end
      end
      return outcome;
   endfunction

   // Offers one request word and records its expected response once it is taken.
   task automatic send_word(logic mode, logic [DEADLINE_W-1:0] deadline,
                            logic [HANDLE_W-1:0] handle);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= mode;
      req_bus.deadline <= deadline;
      req_bus.handle   <= handle;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      expected_outcomes.push_back(predict_timer_event(mode, deadline, handle));
      words_sent++;
   endtask

   // Builds a random request, with deadlines biased towards ties and extremes.
   task automatic send_random_word(int add_pct);
      logic                  mode;
      logic [DEADLINE_W-1:0] deadline;
      int                    pick;
      mode = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_IRQ;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         deadline = $urandom_range(0, 15);
      else if (pick < 50) begin
         case ($urandom_range(0, 4))
            0: deadline = 32'h0000_0000;
            1: deadline = 32'h0000_0001;
            2: deadline = 32'h8000_0000;
            3: deadline = 32'hFFFF_FFFE;
            default: deadline = 32'hFFFF_FFFF;
         endcase
      end else
         deadline = $urandom;
      send_word(mode, deadline, HANDLE_W'($urandom_range(0, 255)));
   endtask

   // Waits until every response is back and the block has settled.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Writes the tick rate while the block is idle.
   task automatic write_tick_rate(logic [RATE_W-1:0] rate);
      wait_until_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= rate;
      do @(negedge clock); while (!csr_bus.ready);
      @(posedge clock);
      csr_bus.valid   <= 1'b0;
      model_tick_rate = rate;
      rate_writes++;
   endtask

   // Cycles through the extreme rates, the reset value and random ones.
   function automatic logic [RATE_W-1:0] next_tick_rate();
      logic [RATE_W-1:0] rate;
      case (rate_pick % 6)
         0: rate = 32'd1;
         1: rate = 32'hFFFF_FFFF;
         2: rate = 32'd0;
         3: rate = TICK_RATE_RESET;
         default: rate = $urandom;
      endcase
      rate_pick++;
      return rate;
   endfunction

   // Compares one field of a response word.
   task automatic check_field(string field_name, logic [TICKS_W-1:0] want,
                              logic [TICKS_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
      end
   endtask

   // Response side: drives ready, honours hold-off requests and checks each word taken.
   initial begin
      int                hold_left;
      int                hold_seen;
      timer_outcome_type want;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         // The word seen here is the one taken at the next rising edge.
         @(negedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: response word with none expected, actual fired=%0b handle=%0h",
                        $time, rsp_bus.fired, rsp_bus.fired_handle);
               $display("%0t: actual arm=%0b ticks=%0h full=%0b", $time,
                        rsp_bus.arm_valid, rsp_bus.arm_ticks, rsp_bus.full_error);
            end else begin
               want = expected_outcomes.pop_front();
               check_field("fired", TICKS_W'(want.fired), TICKS_W'(rsp_bus.fired));
               check_field("fired_handle", TICKS_W'(want.fired_handle),
                           TICKS_W'(rsp_bus.fired_handle));
               check_field("arm_valid", TICKS_W'(want.arm_valid), TICKS_W'(rsp_bus.arm_valid));
               check_field("arm_ticks", want.arm_ticks, rsp_bus.arm_ticks);
               check_field("full_error", TICKS_W'(want.full_error),
                           TICKS_W'(rsp_bus.full_error));
               outcomes_checked++;
               if (want.fired) fires_seen++;
               if (want.full_error) refusals_seen++;
               if (want.arm_valid && want.arm_ticks == ARM_DISARMED) disarms_seen++;
            end
         end
      end
   end

   // Interrupt on an empty queue, extreme deadlines and handles, and a tie.
   task automatic test_directed_extremes();
      send_word(MODE_IRQ, 32'h0, 8'h00);
      send_word(MODE_ADD, 32'hFFFF_FFFF, 8'hFF);
      send_word(MODE_ADD, 32'h0000_0000, 8'h00);
      send_word(MODE_ADD, 32'h0000_0000, 8'h01);
      send_word(MODE_ADD, 32'h0000_0005, 8'h02);
   endtask

   // Fills the queue, has adds refused, then pops the tied heads in arrival order.
   task automatic test_fill_to_full();
      while (model_timers.size() < QUEUE_DEPTH)
         send_word(MODE_ADD, $urandom_range(0, 40), HANDLE_W'($urandom_range(0, 255)));
      send_word(MODE_ADD, 32'h0, 8'hA5);
      send_word(MODE_ADD, 32'hFFFF_FFFF, 8'h5A);
      repeat (3) send_word(MODE_IRQ, $urandom, HANDLE_W'($urandom_range(0, 255)));
   endtask

   // Long receiver hold-off while requests keep coming, so the input stalls.
   task automatic test_backpressure();
      wait_until_idle();
      hold_asks++;
      repeat (30) send_random_word(70);
   endtask

   // Bursts of random traffic, with a new tick rate every few bursts.
   task automatic test_random_traffic(int words);
      int burst;
      int add_pct;
      for (burst = 0; burst < words / BURST_WORDS; burst++) begin
         if (burst % 3 == 0)
            write_tick_rate(next_tick_rate());
         case ($urandom_range(0, 3))
            0: add_pct = 25;
            1: add_pct = 50;
            2: add_pct = 65;
            default: add_pct = 85;
         endcase
         repeat (BURST_WORDS) send_random_word(add_pct);
      end
   endtask

   // Empties the queue, then interrupts twice more with nothing pending.
   task automatic test_drain();
      while (model_timers.size() > 0)
         send_word(MODE_IRQ, $urandom, HANDLE_W'($urandom_range(0, 255)));
      repeat (2) send_word(MODE_IRQ, $urandom, HANDLE_W'($urandom_range(0, 255)));
   endtask

   // Main sequence.
   initial begin
      error_count      = 0;
      words_sent       = 0;
      outcomes_checked = 0;
      fires_seen       = 0;
      refusals_seen    = 0;
      disarms_seen     = 0;
      rate_writes      = 0;
      rate_pick        = 0;
      hold_asks        = 0;
      model_tick_rate  = TICK_RATE_RESET;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.mode     <= MODE_ADD;
      req_bus.deadline <= '0;
      req_bus.handle   <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.data     <= '0;

      send_idle_pct = 13;
      recv_idle_pct = 79;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_fill_to_full();
      test_random_traffic(540);

      send_idle_pct = 79;
      recv_idle_pct = 13;
      test_random_traffic(540);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_traffic(480);
      test_drain();

      wait_until_idle();
      repeat (SETTLE_WAIT) @(posedge clock);
      $display("Run covered %0d requests and %0d checked responses:", words_sent,
               outcomes_checked);
      $display("%0d fired, %0d refused adds, %0d disarms, %0d tick rate writes.",
               fires_seen, refusals_seen, disarms_seen, rate_writes);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/steq_pkg.sv
design/steq_req_if.sv
design/steq_rsp_if.sv
design/steq_csr_if.sv
design/steq_cell.sv
design/sorted_timer_event_queue_unit.sv
verif/tb_sorted_timer_event_queue_unit.sv
